### sv/scfp_pkg.sv
// shared types and constants of the serial command frame parser
`timescale 1ns / 1ps
package scfp_pkg;

   // frame symbols
   localparam logic [7:0] SYM_START  = 8'h23;
   localparam logic [7:0] SYM_INCLI  = 8'h40;
   localparam logic [7:0] SYM_LOWPWR = 8'h2B;
   localparam logic [7:0] SYM_PANEL  = 8'h25;
   localparam logic [7:0] SYM_BATT   = 8'h24;
   localparam logic [7:0] SYM_CLOCK  = 8'h26;

   // event codes on the result channel
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_INCLI   = 3'd1;
   localparam logic [2:0] EV_LOWPWR  = 3'd2;
   localparam logic [2:0] EV_PANEL   = 3'd3;
   localparam logic [2:0] EV_BATT    = 3'd4;
   localparam logic [2:0] EV_CLOCK   = 3'd5;
   localparam logic [2:0] EV_CKS_ERR = 3'd6;
   localparam logic [2:0] EV_TIMEOUT = 3'd7;

   // date-time byte slots
   localparam int NUM_FIELDS = 6;
   localparam logic [2:0] SLOT_YEAR   = 3'd0;
   localparam logic [2:0] SLOT_MONTH  = 3'd1;
   localparam logic [2:0] SLOT_DAY    = 3'd2;
   localparam logic [2:0] SLOT_HOUR   = 3'd3;
   localparam logic [2:0] SLOT_MINUTE = 3'd4;
   localparam logic [2:0] SLOT_SECOND = 3'd5;

   // parser states
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CMD    = 9'b000000010,
      ST_YEAR   = 9'b000000100,
      ST_MONTH  = 9'b000001000,
      ST_DAY    = 9'b000010000,
      ST_HOUR   = 9'b000100000,
      ST_MINUTE = 9'b001000000,
      ST_SECOND = 9'b010000000,
      ST_CKS    = 9'b100000000
   } state_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic [2:0] ev;
      logic       restart;
      logic       store;
      logic [2:0] slot;
      logic       check;
      logic [7:0] data;
   } op_type;

endpackage

### sv/scfp_front.sv
// front end: frame state machine that classifies each received byte
`timescale 1ns / 1ps
module scfp_front
   import scfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       timed_out,
   output op_type     op
);

   state_type state_ff, state_in;

   // classify the byte and pick the next state
   always_comb begin
      state_in   = ST_IDLE;
      op.ev      = EV_NONE;
      op.restart = 1'b0;
      op.store   = 1'b0;
      op.slot    = SLOT_YEAR;
      op.check   = 1'b0;
      op.data    = data_byte;
      if (state_ff == ST_IDLE) begin
         if (data_byte == SYM_START) begin
            op.restart = 1'b1;
            state_in   = ST_CMD;
         end
      end else if (timed_out) begin
         op.ev = EV_TIMEOUT;
      end else begin
         unique case (state_ff)
            ST_CMD: begin
               op.restart = 1'b1;
               unique case (data_byte)
                  SYM_INCLI:  op.ev = EV_INCLI;
                  SYM_LOWPWR: op.ev = EV_LOWPWR;
                  SYM_PANEL:  op.ev = EV_PANEL;
                  SYM_BATT:   op.ev = EV_BATT;
                  SYM_CLOCK:  state_in = ST_YEAR;
                  default:    op.ev = EV_NONE;
               endcase
            end
            ST_YEAR: begin
               op.restart = 1'b1; op.store = 1'b1; op.slot = SLOT_YEAR;
               state_in = ST_MONTH;
            end
            ST_MONTH: begin
               op.restart = 1'b1; op.store = 1'b1; op.slot = SLOT_MONTH;
               state_in = ST_DAY;
            end
            ST_DAY: begin
               op.restart = 1'b1; op.store = 1'b1; op.slot = SLOT_DAY;
               state_in = ST_HOUR;
            end
            ST_HOUR: begin
               op.restart = 1'b1; op.store = 1'b1; op.slot = SLOT_HOUR;
               state_in = ST_MINUTE;
            end
            ST_MINUTE: begin
               op.restart = 1'b1; op.store = 1'b1; op.slot = SLOT_MINUTE;
               state_in = ST_SECOND;
            end
            ST_SECOND: begin
               op.restart = 1'b1; op.store = 1'b1; op.slot = SLOT_SECOND;
               state_in = ST_CKS;
            end
            ST_CKS:  op.check = 1'b1;
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // state register advances on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/scfp_queue.sv
// short fifo of classified bytes between front and back
`timescale 1ns / 1ps
module scfp_queue
   import scfp_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head_op
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   op_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_op    = slots_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_op;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### sv/scfp_back.sv
// back end: date-time store, checksum check and result register
`timescale 1ns / 1ps
module scfp_back
   import scfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  op_type     head_op,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_res,
   output logic       rsp_restart_timer,
   output logic [7:0] rsp_year_out,
   output logic [7:0] rsp_month_out,
   output logic [7:0] rsp_day_out,
   output logic [7:0] rsp_hour_out,
   output logic [7:0] rsp_minute_out,
   output logic [7:0] rsp_second_out
);

   logic [7:0] date_ff [NUM_FIELDS];
   logic       valid_ff;
   logic [2:0] ev_ff, ev_in;
   logic       restart_ff;
   logic [7:0] field_ff [NUM_FIELDS];
   logic [7:0] sum;
   logic       match;

   // output register frees when empty or taken
   assign pop = head_valid && (!valid_ff || rsp_ready);

   // mod-256 sum of the stored bytes
   assign sum   = date_ff[0] + date_ff[1] + date_ff[2] + date_ff[3] + date_ff[4] + date_ff[5];
   assign match = (sum == head_op.data);

   // event of the head beat
   always_comb begin
      ev_in = head_op.ev;
      if (head_op.check) begin
         ev_in = match ? EV_CLOCK : EV_CKS_ERR;
      end
   end

   // date-time store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FIELDS; i++) begin
            date_ff[i] <= '0;
         end
      end else if (pop && head_op.store) begin
         date_ff[head_op.slot] <= head_op.data;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         ev_ff      <= ev_in;
         restart_ff <= head_op.restart;
         for (int i = 0; i < NUM_FIELDS; i++) begin
            field_ff[i] <= (head_op.check && match) ? date_ff[i] : 8'd0;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_res     = ev_ff;
   assign rsp_restart_timer = restart_ff;
   assign rsp_year_out      = field_ff[SLOT_YEAR];
   assign rsp_month_out     = field_ff[SLOT_MONTH];
   assign rsp_day_out       = field_ff[SLOT_DAY];
   assign rsp_hour_out      = field_ff[SLOT_HOUR];
   assign rsp_minute_out    = field_ff[SLOT_MINUTE];
   assign rsp_second_out    = field_ff[SLOT_SECOND];

endmodule

### sv/serial_command_frame_parser_unit.sv
// Serial command frame parser, top level.
// Input channel (req_): one received serial byte per beat with its
// inter-byte timeout flag. Result channel (rsp_): exactly one result beat
// per input beat, in order: event code, timer restart request and the
// six date-time bytes (nonzero only with a set-clock event).
// A byte is written into the queue at the edge that accepts it; the result
// register is loaded from the queue head when it is empty or being taken,
// and the result beat is offered from it.
// Throughput: one byte per cycle while the queue is not full; the front state
// machine and the back checksum adder are each combinational.
// The queue between front and back holds QUEUE_DEPTH beats; when the
// receiver stalls, the result register holds, the queue fills and
// req_ready drops once it is full.
// Reset returns the parser to idle, empties the queue and result register
// and clears the stored date-time bytes.
`timescale 1ns / 1ps
module serial_command_frame_parser_unit
   import scfp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_timed_out,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_res,
   output logic       rsp_restart_timer,
   output logic [7:0] rsp_year_out,
   output logic [7:0] rsp_month_out,
   output logic [7:0] rsp_day_out,
   output logic [7:0] rsp_hour_out,
   output logic [7:0] rsp_minute_out,
   output logic [7:0] rsp_second_out
);

   logic   accept;
   logic   full;
   logic   pop;
   logic   head_valid;
   op_type front_op;
   op_type head_op;

   assign req_ready = !full;
   assign accept    = req_valid && !full;

   // front: classify bytes
   scfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .timed_out (req_timed_out),
      .op        (front_op)
   );

   // queue between the halves
   scfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_op    (front_op),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   // back: execute and present results
   scfp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_op           (head_op),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_restart_timer (rsp_restart_timer),
      .rsp_year_out      (rsp_year_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_day_out       (rsp_day_out),
      .rsp_hour_out      (rsp_hour_out),
      .rsp_minute_out    (rsp_minute_out),
      .rsp_second_out    (rsp_second_out)
   );

endmodule

### sv/scfp_checker.sv
// port-level assertions for the serial command frame parser
`timescale 1ns / 1ps
module scfp_checker
   import scfp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       req_timed_out,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_res,
   input logic       rsp_restart_timer,
   input logic [7:0] rsp_year_out,
   input logic [7:0] rsp_month_out,
   input logic [7:0] rsp_day_out,
   input logic [7:0] rsp_hour_out,
   input logic [7:0] rsp_minute_out,
   input logic [7:0] rsp_second_out
);

   // stalled result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res))
      else $error("stalled result beat changed");

   // date bytes only travel with a set-clock event
   a_date_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_CLOCK |->
         rsp_year_out == 8'd0 && rsp_month_out == 8'd0 && rsp_day_out == 8'd0 &&
         rsp_hour_out == 8'd0 && rsp_minute_out == 8'd0 && rsp_second_out == 8'd0)
      else $error("date bytes with wrong event");

   // timeout abort and checksum outcomes never restart the timer
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_TIMEOUT || rsp_event_res == EV_CLOCK ||
                    rsp_event_res == EV_CKS_ERR) |-> !rsp_restart_timer)
      else $error("restart with frame-ending event");

   // command events always come from an in-frame byte that restarts the timer
   a_cmd_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_INCLI || rsp_event_res == EV_LOWPWR ||
                    rsp_event_res == EV_PANEL || rsp_event_res == EV_BATT)
         |-> rsp_restart_timer)
      else $error("command event without restart");

   // no result appears right out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind serial_command_frame_parser_unit scfp_checker u_scfp_checker (.*);

### tb/scfp_frame_checker.sv
// result predictor and scoreboard for the serial command frame parser
`timescale 1ns / 1ps
module scfp_frame_checker
   import scfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_timed_out,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [2:0] rsp_event_res,
   input  logic       rsp_restart_timer,
   input  logic [7:0] rsp_year_out,
   input  logic [7:0] rsp_month_out,
   input  logic [7:0] rsp_day_out,
   input  logic [7:0] rsp_hour_out,
   input  logic [7:0] rsp_minute_out,
   input  logic [7:0] rsp_second_out,
   output int         fail_count,
   output int         pending
);

   // where the parser stands within a frame
   typedef enum logic [3:0] {
      PS_IDLE, PS_CMD, PS_YEAR, PS_MONTH, PS_DAY, PS_HOUR, PS_MINUTE, PS_SECOND, PS_CKS
   } parse_phase_type;

   typedef struct packed {
      logic [2:0]      ev;
      logic            restart;
      logic [5:0][7:0] stamp;
   } frame_result_type;

   parse_phase_type  phase;
   logic [5:0][7:0]  stamp_regs;
   frame_result_type expected_results[$];
   frame_result_type seen;
   frame_result_type want;

   // advance the frame state by one byte and return the result it causes
   function automatic frame_result_type decode_frame_byte(input logic [7:0] b,
                                                          input logic tmo);
      frame_result_type r;
      logic [7:0]       sum;
      r = '0;
      sum = '0;
      for (int i = 0; i < NUM_FIELDS; i++) sum = sum + stamp_regs[i];
      if (phase == PS_IDLE) begin
         // timeout flag means nothing outside a frame
         if (b == SYM_START) begin
            r.restart = 1'b1;
            phase = PS_CMD;
         end
      end else if (tmo) begin
         r.ev = EV_TIMEOUT;
         phase = PS_IDLE;
      end else if (phase == PS_CKS) begin
         if (sum == b) begin
            r.ev = EV_CLOCK;
            r.stamp = stamp_regs;
         end else begin
            r.ev = EV_CKS_ERR;
         end
         phase = PS_IDLE;
      end else if (phase == PS_CMD) begin
         // unknown command still restarts the timer
         r.restart = 1'b1;
         phase = PS_IDLE;
         case (b)
            SYM_INCLI:  r.ev = EV_INCLI;
            SYM_LOWPWR: r.ev = EV_LOWPWR;
            SYM_PANEL:  r.ev = EV_PANEL;
            SYM_BATT:   r.ev = EV_BATT;
            SYM_CLOCK:  phase = PS_YEAR;
            default:    r.ev = EV_NONE;
         endcase
      end else begin
         r.restart = 1'b1;
         stamp_regs[int'(phase) - int'(PS_YEAR)] = b;
         phase = parse_phase_type'(int'(phase) + 1);
      end
      return r;
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= 10)
         $display({"%0t ns: %s: expected ev %0d restart %0b stamp %h, ",
                   "got ev %0d restart %0b stamp %h"},
                  $time, what, want.ev, want.restart, want.stamp,
                  seen.ev, seen.restart, seen.stamp);
   endtask

   // predict on every input beat, compare on every result beat
   always @(posedge clock) begin
      if (reset) begin
         phase = PS_IDLE;
         stamp_regs = '0;
         expected_results.delete();
         pending = 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(decode_frame_byte(req_data_byte, req_timed_out));
         if (rsp_valid && rsp_ready) begin
            seen.ev = rsp_event_res;
            seen.restart = rsp_restart_timer;
            seen.stamp[SLOT_YEAR] = rsp_year_out;
            seen.stamp[SLOT_MONTH] = rsp_month_out;
            seen.stamp[SLOT_DAY] = rsp_day_out;
            seen.stamp[SLOT_HOUR] = rsp_hour_out;
            seen.stamp[SLOT_MINUTE] = rsp_minute_out;
            seen.stamp[SLOT_SECOND] = rsp_second_out;
            if (expected_results.size() == 0) begin
               want = 'x;
               note_failure("unexpected result beat");
            end else begin
               want = expected_results.pop_front();
               if (seen.ev !== want.ev || seen.restart !== want.restart ||
                   seen.stamp !== want.stamp)
                  note_failure("result mismatch");
            end
         end
         pending = expected_results.size();
      end
   end

endmodule

### tb/tb_serial_command_frame_parser_unit.sv
// stimulus and verdict for the serial command frame parser testbench
`timescale 1ns / 1ps
module tb_serial_command_frame_parser_unit;
   import scfp_pkg::*;

   localparam int TOTAL_BEATS = 1350;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_timed_out = 1'b0;
   logic       rsp_ready = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [2:0] rsp_event_res;
   logic       rsp_restart_timer;
   logic [7:0] rsp_year_out;
   logic [7:0] rsp_month_out;
   logic [7:0] rsp_day_out;
   logic [7:0] rsp_hour_out;
   logic [7:0] rsp_minute_out;
   logic [7:0] rsp_second_out;
   int         fail_count;
   int         pending;

   bit idle_on = 1'b1;
   int hold_req = 0;
   int hold_left = 0;
   int beats_sent = 0;
   int noise_sent = 0;
   int loads_sent = 0;
   int cmds_sent = 0;
   int aborts_sent = 0;

   always #10 clock = ~clock;

   serial_command_frame_parser_unit i_dut (.*);

   scfp_frame_checker i_checker (.*);

   // hard stop in case the block hangs
   initial begin
      #(5_000_000);
      $display("end of test: mismatches");
      $finish;
   end

   // receiver side: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_on || ($urandom_range(0, 99) >= 22);
      end
   end

   // one input beat, entered and left at a falling edge
   task automatic send_beat(input logic [7:0] b, input logic tmo);
      int gap;
      gap = 0;
      if (idle_on)
         while ($urandom_range(0, 99) < 22) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_timed_out <= tmo;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // full date-time load, checksum good or corrupted
   task automatic send_load(input logic [5:0][7:0] stamp, input bit good);
      logic [7:0] sum;
      sum = '0;
      send_beat(SYM_START, $urandom_range(0, 4) == 0);
      send_beat(SYM_CLOCK, 1'b0);
      for (int i = 0; i < NUM_FIELDS; i++) begin
         sum = sum + stamp[i];
         send_beat(stamp[i], 1'b0);
      end
      send_beat(good ? sum : sum ^ 8'($urandom_range(1, 255)), 1'b0);
      loads_sent++;
   endtask

   // stop offering beats and wait for every expected result
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      logic [5:0][7:0] stamp;
      logic [7:0]      cmd;
      int              pick;
      int              depth;
      int              next_drain;
      int              waited;
      bit              hold_done;

      next_drain = 300;
      hold_done = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: idle bytes with and without timeout, every command
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(SYM_START, 1'b1);
      send_beat(SYM_INCLI, 1'b0);
      send_beat(SYM_START, 1'b0);
      send_beat(SYM_LOWPWR, 1'b0);
      send_beat(SYM_START, 1'b0);
      send_beat(SYM_PANEL, 1'b0);
      send_beat(SYM_START, 1'b0);
      send_beat(SYM_BATT, 1'b0);
      // unknown command byte
      send_beat(SYM_START, 1'b0);
      send_beat(8'h5A, 1'b0);
      // all-ones load, checksum wraps past 256
      send_load({NUM_FIELDS{8'hFF}}, 1'b1);
      // timeout on the command byte
      send_beat(SYM_START, 1'b0);
      send_beat(SYM_INCLI, 1'b1);
      cmds_sent += 4;
      aborts_sent++;
      wait_drained();

      // random frames, mostly well formed
      while (beats_sent - noise_sent < TOTAL_BEATS) begin
         if (beats_sent >= next_drain) begin
            wait_drained();
            next_drain += 300;
         end
         idle_on = !(beats_sent >= 500 && beats_sent < 750);
         if (!hold_done && beats_sent >= 900) begin
            hold_req = 80;
            hold_done = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            for (int i = 0; i < NUM_FIELDS; i++) stamp[i] = pick_byte();
            send_load(stamp, $urandom_range(0, 4) != 0);
         end else if (pick < 60) begin
            case ($urandom_range(0, 3))
               0:       cmd = SYM_INCLI;
               1:       cmd = SYM_LOWPWR;
               2:       cmd = SYM_PANEL;
               default: cmd = SYM_BATT;
            endcase
            send_beat(SYM_START, $urandom_range(0, 4) == 0);
            send_beat(cmd, 1'b0);
            cmds_sent++;
         end else if (pick < 72) begin
            // load cut short by a timeout, possibly on the checksum
            depth = $urandom_range(0, NUM_FIELDS);
            send_beat(SYM_START, 1'b0);
            send_beat(SYM_CLOCK, 1'b0);
            for (int i = 0; i < depth; i++) send_beat(pick_byte(), 1'b0);
            send_beat(pick_byte(), 1'b1);
            aborts_sent++;
         end else if (pick < 80) begin
            send_beat(SYM_START, 1'b0);
            send_beat(pick_byte(), 1'b0);
         end else if (pick < 88) begin
            send_beat(SYM_START, 1'b0);
            send_beat(pick_byte(), 1'b1);
            aborts_sent++;
         end else begin
            depth = $urandom_range(1, 3);
            for (int i = 0; i < depth; i++) begin
               send_beat(pick_byte(), 1'($urandom_range(0, 1)));
               noise_sent++;
            end
         end
      end
      req_valid <= 1'b0;
      idle_on = 1'b1;

      // drain, then stay quiet to catch stray results
      waited = 0;
      while (pending != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (6) @(negedge clock);

      $display("run covered %0d input beats: %0d date-time loads, %0d command frames,",
               beats_sent, loads_sent, cmds_sent);
      $display("%0d timeout aborts, random stalls on both sides and one long receiver hold",
               aborts_sent);
      if (fail_count == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
